/* hdl/strongly_connected_components_defines.svh */
// assertion macros used by the asserting top-level file
`ifndef STRONGLY_CONNECTED_COMPONENTS_DEFINES_SVH
`define STRONGLY_CONNECTED_COMPONENTS_DEFINES_SVH

// same-cycle implication
`define SCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scc check failed");

// next-cycle implication
`define SCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scc check failed");

`endif

/* hdl/scc_pkg.sv */
`timescale 1ns / 1ps
package scc_pkg;
  localparam int VTX_W = 6;
  localparam int NV_W  = 7;
  localparam int ACT_W = 2;

  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RUN   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ADD,
    OP_CLEAR,
    OP_FWD_INIT,
    OP_ROOT_START,
    OP_ROOT_NEXT,
    OP_F_PUSH,
    OP_F_NEXT,
    OP_F_POP,
    OP_F_RESTORE,
    OP_R_INIT,
    OP_FIN_POP,
    OP_R_START,
    OP_R_CMP,
    OP_R_POP,
    OP_R_ADV,
    OP_R_PUSH,
    OP_R_RESTORE,
    OP_E_POP,
    OP_E_LOAD
  } dp_op_t;

  typedef struct packed {
    logic root_end;
    logic root_vis;
    logic scan_end;
    logic fwd_hit;
    logic ss_empty;
    logic fin_empty;
    logic fin_vis;
    logic best_ok;
    logic best_vis;
    logic mem_empty;
  } scc_stat_t;
endpackage

/* hdl/scc_ctrl.sv */
`timescale 1ns / 1ps
module scc_ctrl import scc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [ACT_W-1:0] action,
  input  logic             out_free,
  input  scc_stat_t        stat,
  output logic             in_ready,
  output dp_op_t           op
);
  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_FRD, S_FCHK, S_FRES, S_RFIN, S_RFCHK,
    S_RRD, S_RCHK, S_RRES, S_EPOP, S_ELOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          case (action)
            ACT_ADD:   op = OP_ADD;
            ACT_CLEAR: op = OP_CLEAR;
            ACT_RUN: begin
              op        = OP_FWD_INIT;
              state_nxt = S_ROOT;
            end
            default:   op = OP_NONE;
          endcase
        end
      end
      S_ROOT: begin
        if (stat.root_end) begin
          op        = OP_R_INIT;
          state_nxt = S_RFIN;
        end else if (stat.root_vis) begin
          op = OP_ROOT_NEXT;
        end else begin
          op        = OP_ROOT_START;
          state_nxt = S_FRD;
        end
      end
      S_FRD: state_nxt = S_FCHK;
      S_FCHK: begin
        if (stat.scan_end) begin
          op        = OP_F_POP;
          state_nxt = stat.ss_empty ? S_ROOT : S_FRES;
        end else if (stat.fwd_hit) begin
          op        = OP_F_PUSH;
          state_nxt = S_FRD;
        end else begin
          op        = OP_F_NEXT;
          state_nxt = S_FRD;
        end
      end
      S_FRES: begin
        op        = OP_F_RESTORE;
        state_nxt = S_FRD;
      end
      S_RFIN: begin
        if (stat.fin_empty) begin
          state_nxt = S_IDLE;
        end else begin
          op        = OP_FIN_POP;
          state_nxt = S_RFCHK;
        end
      end
      S_RFCHK: begin
        if (stat.fin_vis) begin
          state_nxt = S_RFIN;
        end else begin
          op        = OP_R_START;
          state_nxt = S_RRD;
        end
      end
      S_RRD: state_nxt = S_RCHK;
      S_RCHK: begin
        if (!stat.scan_end) begin
          op        = OP_R_CMP;
          state_nxt = S_RRD;
        end else if (!stat.best_ok) begin
          op        = OP_R_POP;
          state_nxt = stat.ss_empty ? S_EPOP : S_RRES;
        end else if (stat.best_vis) begin
          op        = OP_R_ADV;
          state_nxt = S_RRD;
        end else begin
          op        = OP_R_PUSH;
          state_nxt = S_RRD;
        end
      end
      S_RRES: begin
        op        = OP_R_RESTORE;
        state_nxt = S_RRD;
      end
      S_EPOP: begin
        if (out_free) begin
          op        = OP_E_POP;
          state_nxt = S_ELOAD;
        end
      end
      S_ELOAD: begin
        op        = OP_E_LOAD;
        state_nxt = stat.mem_empty ? S_RFIN : S_EPOP;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;
endmodule

/* hdl/scc_dp.sv */
`timescale 1ns / 1ps
module scc_dp import scc_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_op_t           op,
  input  logic [VTX_W-1:0] in_from,
  input  logic [VTX_W-1:0] in_to,
  input  logic             cfg_we,
  input  logic [NV_W-1:0]  cfg_value,
  input  logic             out_ready,
  output scc_stat_t        stat,
  output logic             out_valid,
  output logic [VTX_W-1:0] out_vertex,
  output logic [VTX_W-1:0] out_comp,
  output logic             out_first,
  output logic             out_last_comp,
  output logic             out_last_run,
  output logic             out_dropped
);
  localparam int SW   = $clog2(MAX_VERTICES);
  localparam int SDW  = $clog2(MAX_VERTICES + 1);
  localparam int EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int SSEW = 2 * VTX_W + 1 + ECW;

  logic [2*VTX_W-1:0] edge_mem [MAX_EDGES];
  logic [SSEW-1:0]    ss_mem   [MAX_VERTICES];
  logic [VTX_W-1:0]   fin_mem  [MAX_VERTICES];
  logic [VTX_W-1:0]   mem_mem  [MAX_VERTICES];

  logic [2*VTX_W-1:0] edge_rd_r;
  logic [SSEW-1:0]    ss_rd_r;
  logic [VTX_W-1:0]   fin_rd_r, mem_rd_r;

  logic [ECW-1:0]          etot_r;
  logic                    drop_r;
  logic [NV_W-1:0]         nv_r;
  logic [MAX_VERTICES-1:0] visited_r;
  logic [NV_W-1:0]         root_r;
  logic [VTX_W-1:0]        top_v_r;
  logic [ECW-1:0]          scan_r;
  logic                    pv_r, bv_r;
  logic [VTX_W-1:0]        psrc_r, bsrc_r;
  logic [ECW-1:0]          pe_r, be_r;
  logic [SDW-1:0]          ss_depth_r, fd_r, md_r;
  logic [NV_W-1:0]         cnt_r;
  logic [VTX_W-1:0]        comp_r;
  logic                    first_r;

  logic                    out_valid_r;
  logic [VTX_W-1:0]        out_vertex_r, out_comp_r;
  logic                    out_first_r, out_last_comp_r, out_last_run_r, out_dropped_r;

  logic [VTX_W-1:0] e_src, e_dst;
  logic             e_dst_ok, e_src_ok, rev_cand, add_ok;
  logic [SW-1:0]    ss_ra, fin_ra, mem_ra;
  logic [NV_W-1:0]  cfg_clamp;

  assign e_src    = edge_rd_r[2*VTX_W-1:VTX_W];
  assign e_dst    = edge_rd_r[VTX_W-1:0];
  assign e_dst_ok = {1'b0, e_dst} < nv_r;
  assign e_src_ok = {1'b0, e_src} < nv_r;
  // reversed edges ordered by (source, insertion index), strictly after the previous one
  assign rev_cand = (e_dst == top_v_r) && e_src_ok &&
                    (!pv_r || {e_src, scan_r} > {psrc_r, pe_r}) &&
                    (!bv_r || {e_src, scan_r} < {bsrc_r, be_r});
  assign add_ok   = ({1'b0, in_from} < nv_r) && ({1'b0, in_to} < nv_r) &&
                    (etot_r < ECW'(MAX_EDGES));

  assign ss_ra  = SW'(ss_depth_r - SDW'(1));
  assign fin_ra = SW'(fd_r - SDW'(1));
  assign mem_ra = SW'(md_r - SDW'(1));

  always_comb begin
    if (cfg_value == '0)
      cfg_clamp = NV_W'(1);
    else if (cfg_value > NV_W'(MAX_VERTICES))
      cfg_clamp = NV_W'(MAX_VERTICES);
    else
      cfg_clamp = cfg_value;
  end

  always_comb begin
    stat.root_end  = root_r >= nv_r;
    stat.root_vis  = visited_r[root_r[SW-1:0]];
    stat.scan_end  = scan_r >= etot_r;
    stat.fwd_hit   = (e_src == top_v_r) && e_dst_ok && !visited_r[e_dst[SW-1:0]];
    stat.ss_empty  = ss_depth_r == '0;
    stat.fin_empty = fd_r == '0;
    stat.fin_vis   = visited_r[fin_rd_r[SW-1:0]];
    stat.best_ok   = bv_r;
    stat.best_vis  = visited_r[bsrc_r[SW-1:0]];
    stat.mem_empty = md_r == '0;
  end

  // memories: one write port each, read data registered
  always_ff @(posedge clk) begin
    edge_rd_r <= edge_mem[scan_r[EW-1:0]];
    ss_rd_r   <= ss_mem[ss_ra];
    fin_rd_r  <= fin_mem[fin_ra];
    mem_rd_r  <= mem_mem[mem_ra];
    if (op == OP_ADD && add_ok)
      edge_mem[etot_r[EW-1:0]] <= {in_from, in_to};
    if (op == OP_F_PUSH)
      ss_mem[ss_depth_r[SW-1:0]] <= {top_v_r, 1'b0, {VTX_W{1'b0}}, scan_r + ECW'(1)};
    if (op == OP_R_PUSH)
      ss_mem[ss_depth_r[SW-1:0]] <= {top_v_r, pv_r, psrc_r, pe_r};
    if (op == OP_F_POP)
      fin_mem[fd_r[SW-1:0]] <= top_v_r;
    if (op == OP_R_POP)
      mem_mem[md_r[SW-1:0]] <= top_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      etot_r      <= '0;
      drop_r      <= 1'b0;
      nv_r        <= NV_W'(1);
      visited_r   <= '0;
      root_r      <= '0;
      scan_r      <= '0;
      pv_r        <= 1'b0;
      bv_r        <= 1'b0;
      ss_depth_r  <= '0;
      fd_r        <= '0;
      md_r        <= '0;
      cnt_r       <= '0;
      comp_r      <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we)
        nv_r <= cfg_clamp;
      if (op == OP_E_LOAD)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
      case (op)
        OP_ADD: begin
          if (add_ok)
            etot_r <= etot_r + ECW'(1);
          else
            drop_r <= 1'b1;
        end
        OP_CLEAR: begin
          etot_r <= '0;
          drop_r <= 1'b0;
        end
        OP_FWD_INIT: begin
          visited_r <= '0;
          fd_r      <= '0;
          root_r    <= '0;
        end
        OP_ROOT_START: begin
          visited_r[root_r[SW-1:0]] <= 1'b1;
          top_v_r    <= root_r[VTX_W-1:0];
          scan_r     <= '0;
          ss_depth_r <= '0;
        end
        OP_ROOT_NEXT: root_r <= root_r + NV_W'(1);
        OP_F_PUSH: begin
          visited_r[e_dst[SW-1:0]] <= 1'b1;
          ss_depth_r <= ss_depth_r + SDW'(1);
          top_v_r    <= e_dst;
          scan_r     <= '0;
        end
        OP_F_NEXT: scan_r <= scan_r + ECW'(1);
        OP_F_POP: begin
          fd_r <= fd_r + SDW'(1);
          if (ss_depth_r != '0)
            ss_depth_r <= ss_depth_r - SDW'(1);
        end
        OP_F_RESTORE: begin
          top_v_r <= ss_rd_r[SSEW-1 -: VTX_W];
          scan_r  <= ss_rd_r[ECW-1:0];
        end
        OP_R_INIT: begin
          visited_r <= '0;
          comp_r    <= '0;
          cnt_r     <= '0;
          first_r   <= 1'b1;
        end
        OP_FIN_POP: fd_r <= fd_r - SDW'(1);
        OP_R_START: begin
          visited_r[fin_rd_r[SW-1:0]] <= 1'b1;
          top_v_r    <= fin_rd_r;
          pv_r       <= 1'b0;
          bv_r       <= 1'b0;
          scan_r     <= '0;
          ss_depth_r <= '0;
          md_r       <= '0;
        end
        OP_R_CMP: begin
          if (rev_cand) begin
            bv_r   <= 1'b1;
            bsrc_r <= e_src;
            be_r   <= scan_r;
          end
          scan_r <= scan_r + ECW'(1);
        end
        OP_R_POP: begin
          md_r <= md_r + SDW'(1);
          if (ss_depth_r != '0)
            ss_depth_r <= ss_depth_r - SDW'(1);
        end
        OP_R_ADV: begin
          pv_r   <= 1'b1;
          psrc_r <= bsrc_r;
          pe_r   <= be_r;
          bv_r   <= 1'b0;
          scan_r <= '0;
        end
        OP_R_PUSH: begin
          visited_r[bsrc_r[SW-1:0]] <= 1'b1;
          ss_depth_r <= ss_depth_r + SDW'(1);
          top_v_r    <= bsrc_r;
          pv_r       <= 1'b0;
          bv_r       <= 1'b0;
          scan_r     <= '0;
        end
        OP_R_RESTORE: begin
          top_v_r <= ss_rd_r[SSEW-1 -: VTX_W];
          pv_r    <= ss_rd_r[ECW+VTX_W];
          psrc_r  <= ss_rd_r[ECW+VTX_W-1 -: VTX_W];
          pe_r    <= ss_rd_r[ECW-1:0];
          bv_r    <= 1'b0;
          scan_r  <= '0;
        end
        OP_E_POP: md_r <= md_r - SDW'(1);
        OP_E_LOAD: begin
          cnt_r   <= cnt_r + NV_W'(1);
          first_r <= (md_r == '0);
          if (md_r == '0)
            comp_r <= comp_r + VTX_W'(1);
        end
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (op == OP_E_LOAD) begin
      out_vertex_r    <= mem_rd_r;
      out_comp_r      <= comp_r;
      out_first_r     <= first_r;
      out_last_comp_r <= (md_r == '0);
      out_last_run_r  <= (cnt_r == nv_r - NV_W'(1));
      out_dropped_r   <= drop_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_vertex    = out_vertex_r;
  assign out_comp      = out_comp_r;
  assign out_first     = out_first_r;
  assign out_last_comp = out_last_comp_r;
  assign out_last_run  = out_last_run_r;
  assign out_dropped   = out_dropped_r;
endmodule

/* hdl/strongly_connected_components.sv */
`timescale 1ns / 1ps
// channel | ports                         | payload
// in      | in_tvalid/in_tready           | tuser action, tdata from_vertex, to_vertex
// out     | out_tvalid/out_tready         | tdata vertex, component_index, tuser flags, tlast
// cfg     | cfg_valid/cfg_ready           | cfg_data vertex_count
// add-edge and clear transactions are accepted back to back.
// in a run's forward pass every vertex rescans the edge store, and each reversed step
// rescans the whole store, one entry per read and check state pair through the registered
// read port; each result passes through a pop state and a load state.
// reset is synchronous; memories hold no reset and need no clearing pass.
// a stalled result holds the run at that member; config is always ready.
`include "strongly_connected_components_defines.svh"
module strongly_connected_components import scc_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // from_vertex[5:0], to_vertex[11:6], zero fill
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // vertex[5:0], component_index[11:6], zero fill
  output logic [2:0]  out_tuser,  // first_of_component, last_of_component, edges_dropped
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  dp_op_t           op;
  scc_stat_t        stat;
  logic [VTX_W-1:0] vtx, comp;
  logic             first, last_comp, dropped;

  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .action   (in_tuser),
    .out_free (!out_tvalid || out_tready),
    .stat     (stat),
    .in_ready (in_tready),
    .op       (op)
  );

  scc_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .op            (op),
    .in_from       (in_tdata[5:0]),
    .in_to         (in_tdata[11:6]),
    .cfg_we        (cfg_valid),
    .cfg_value     (cfg_data),
    .out_ready     (out_tready),
    .stat          (stat),
    .out_valid     (out_tvalid),
    .out_vertex    (vtx),
    .out_comp      (comp),
    .out_first     (first),
    .out_last_comp (last_comp),
    .out_last_run  (out_tlast),
    .out_dropped   (dropped)
  );

  assign cfg_ready = 1'b1;
  assign out_tdata = {4'b0, comp, vtx};
  assign out_tuser = {dropped, last_comp, first};

  // a result is never loaded over one still waiting
  `SCC_ASSERT_NOW(a_no_overwrite, op == OP_E_LOAD, !out_tvalid || out_tready)
  // an accepted run keeps the input side closed for the next cycle
  `SCC_ASSERT_NEXT(a_run_busy, in_tvalid && in_tready && in_tuser == ACT_RUN, !in_tready)
  // a loaded result is offered on the next cycle
  `SCC_ASSERT_NEXT(a_load_valid, op == OP_E_LOAD, out_tvalid)
endmodule
